>>> src/sadpcm_pkg.sv
// Shared types and constants for the stereo ADPCM block decoder.
// No dependencies; imported by sadpcm_chan and the top level.
`timescale 1ns / 1ps

package sadpcm_pkg;

	localparam int HistW   = 23;
	localparam int SampleW = 16;
	localparam int HdrW    = 6;	// filter index (5:4) and shift (3:0); bits 7:6 dropped
	localparam int PosW    = 5;

	// Byte positions inside a 32-byte block
	localparam logic [PosW-1:0] PosLeftHdr   = 5'd0;
	localparam logic [PosW-1:0] PosRightHdr  = 5'd1;
	localparam logic [PosW-1:0] PosFirstData = 5'd4;

	// Second-order predictor coefficients, indexed by filter
	localparam logic [6:0] CoefRecent [4] = '{7'd0, 7'd60, 7'd115, 7'd98};
	localparam logic [6:0] CoefOlder  [4] = '{7'd0, 7'd0,  7'd52,  7'd55};

	typedef struct packed {
		logic [7:0] data_byte;
		logic       block_start;
		logic       clear_history;
	} sadpcm_in_t;

	typedef struct packed {
		logic signed [SampleW-1:0] left_sample;
		logic signed [SampleW-1:0] right_sample;
	} sadpcm_out_t;

endpackage

>>> src/stereo_adpcm_block_decoder_core.sv
// Top level of the stereo ADPCM block decoder: byte input register, block
// position/header/history state, two channel decoders and the sample register.
// Depends on sadpcm_pkg and sadpcm_chan.
`timescale 1ns / 1ps

//  channel   ports                                   payload
//  -------   -------------------------------------   -----------------------------------
//  bytes     byte_valid / byte_stall / byte_beat     data_byte, block_start, clear_history
//  samples   sample_valid / sample_stall / sample_beat   left_sample, right_sample
//
// One byte beat per cycle while the sample side does not stall. A byte
// is held in the input register, then the decode (constant-coefficient
// multiply, clamp, add, saturate) runs into the sample register.
// Header and pad bytes update state and produce no sample beat.
// arst_n clears position, headers, histories and both valid flags.
// A stalled sample beat holds the input register; a new byte is still taken
// while the input register is empty.

module stereo_adpcm_block_decoder_core import sadpcm_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        byte_valid,
	output logic        byte_stall,
	input  sadpcm_in_t  byte_beat,
	output logic        sample_valid,
	input  logic        sample_stall,
	output sadpcm_out_t sample_beat
);

	// input register
	sadpcm_in_t beat_s1;
	logic       valid_s1;

	// block state
	logic [PosW-1:0]         pos_q;
	logic [HdrW-1:0]         lhdr_q, rhdr_q;
	logic signed [HistW-1:0] l_rec_q, l_old_q, r_rec_q, r_old_q;

	// result register
	sadpcm_out_t out_q;
	logic        out_valid_q;

	logic                     byte_take, out_free, fire_s1;
	logic [PosW-1:0]          pos_cur;
	logic                     is_data;
	logic signed [HistW-1:0]  l_rec_eff, l_old_eff, r_rec_eff, r_old_eff;
	logic signed [HistW-1:0]  l_next, r_next;
	logic signed [SampleW-1:0] l_smp, r_smp;

	// the sample register frees up when empty or being taken this cycle
	assign out_free   = !out_valid_q || !sample_stall;
	assign fire_s1    = valid_s1 && out_free;
	assign byte_stall = valid_s1 && !out_free;
	assign byte_take  = byte_valid && !byte_stall;

	// block_start realigns to byte 0 regardless of the running position
	assign pos_cur = beat_s1.block_start ? PosLeftHdr : pos_q;
	assign is_data = pos_cur >= PosFirstData;

	// history clear applies before this byte is handled
	assign l_rec_eff = beat_s1.clear_history ? '0 : l_rec_q;
	assign l_old_eff = beat_s1.clear_history ? '0 : l_old_q;
	assign r_rec_eff = beat_s1.clear_history ? '0 : r_rec_q;
	assign r_old_eff = beat_s1.clear_history ? '0 : r_old_q;

	// low nibble feeds left, high nibble feeds right
	sadpcm_chan u_left (
		.header    (lhdr_q),
		.nibble    (beat_s1.data_byte[3:0]),
		.recent    (l_rec_eff),
		.older     (l_old_eff),
		.next_hist (l_next),
		.sample    (l_smp)
	);

	sadpcm_chan u_right (
		.header    (rhdr_q),
		.nibble    (beat_s1.data_byte[7:4]),
		.recent    (r_rec_eff),
		.older     (r_old_eff),
		.next_hist (r_next),
		.sample    (r_smp)
	);

	// input register payload
	always_ff @(posedge clk) begin
		if (byte_take) begin
			beat_s1 <= byte_beat;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= byte_take || (valid_s1 && !out_free);
		end
	end

	// block state advances once per byte leaving the input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			lhdr_q  <= '0;
			rhdr_q  <= '0;
			l_rec_q <= '0;
			l_old_q <= '0;
			r_rec_q <= '0;
			r_old_q <= '0;
		end else if (fire_s1) begin
			pos_q <= pos_cur + 5'd1;	// wraps after byte 31
			if (pos_cur == PosLeftHdr) begin
				lhdr_q <= beat_s1.data_byte[HdrW-1:0];
			end
			if (pos_cur == PosRightHdr) begin
				rhdr_q <= beat_s1.data_byte[HdrW-1:0];
			end
			l_rec_q <= is_data ? l_next : l_rec_eff;
			l_old_q <= is_data ? l_rec_eff : l_old_eff;
			r_rec_q <= is_data ? r_next : r_rec_eff;
			r_old_q <= is_data ? r_rec_eff : r_old_eff;
		end
	end

	// sample register
	always_ff @(posedge clk) begin
		if (fire_s1 && is_data) begin
			out_q.left_sample  <= l_smp;
			out_q.right_sample <= r_smp;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= fire_s1 && is_data;
		end
	end

	assign sample_valid = out_valid_q;
	assign sample_beat  = out_q;

`ifndef NO_ASSERTIONS
	// a sample beat appears only from a byte that sat in the input register
	a_sample_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(sample_valid) |-> $past(valid_s1))
		else $error("sample beat without a byte behind it");

	// histories freeze while the sample side holds a byte back
	a_hist_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && sample_valid && sample_stall) |=>
			($stable(l_rec_q) && $stable(r_rec_q) && $stable(pos_q)))
		else $error("decoder state moved while stalled");

	// a realigned byte is always taken as byte 0
	a_realign: assert property (@(posedge clk) disable iff (!arst_n)
		(fire_s1 && beat_s1.block_start) |=> (pos_q == PosRightHdr))
		else $error("block_start did not realign position");
`endif

endmodule

>>> src/sadpcm_chan.sv
// One channel of the ADPCM decode: prediction, clamp, nibble add, output saturate.
// Purely combinational; depends on sadpcm_pkg.
`timescale 1ns / 1ps

module sadpcm_chan import sadpcm_pkg::*; (
	input  logic [HdrW-1:0]           header,
	input  logic [3:0]                nibble,
	input  logic signed [HistW-1:0]   recent,
	input  logic signed [HistW-1:0]   older,
	output logic signed [HistW-1:0]   next_hist,
	output logic signed [SampleW-1:0] sample
);

	localparam logic signed [31:0] PredMin = -32'sd2097152;
	localparam logic signed [31:0] PredMax =  32'sd2097151;
	localparam logic signed [23:0] OutMin  = -24'sd32768;
	localparam logic signed [23:0] OutMax  =  24'sd32767;

	logic [1:0]              filt;
	logic [3:0]              shamt;
	logic signed [31:0]      rec_ext, old_ext, cr, co;
	logic signed [31:0]      pred_raw, pred_sum, pred_rnd;
	logic signed [21:0]      pred_cl;
	logic signed [15:0]      step, step_sh;
	logic signed [HistW-1:0] delta, nxt;
	logic signed [23:0]      out_sum, out_rnd;

	assign filt  = header[5:4];
	assign shamt = header[3:0];

	always_comb begin
		rec_ext  = 32'(recent);
		old_ext  = 32'(older);
		cr       = {25'd0, CoefRecent[filt]};
		co       = {25'd0, CoefOlder[filt]};
		pred_raw = rec_ext * cr - old_ext * co;
		pred_sum = pred_raw + 32'sd32;
		pred_rnd = pred_sum >>> 6;
		if (pred_rnd < PredMin) begin
			pred_cl = PredMin[21:0];
		end else if (pred_rnd > PredMax) begin
			pred_cl = PredMax[21:0];
		end else begin
			pred_cl = pred_rnd[21:0];
		end

		// signed nibble scaled by 2^12, shifted, then scaled by 2^6
		step    = {nibble, 12'd0};
		step_sh = step >>> shamt;
		delta   = {step_sh[15], step_sh, 6'd0};
		nxt     = {pred_cl[21], pred_cl} + delta;

		out_sum = {nxt[HistW-1], nxt} + 24'sd32;
		out_rnd = out_sum >>> 6;
		if (out_rnd < OutMin) begin
			sample = OutMin[SampleW-1:0];
		end else if (out_rnd > OutMax) begin
			sample = OutMax[SampleW-1:0];
		end else begin
			sample = out_rnd[SampleW-1:0];
		end
	end

	assign next_hist = nxt;

endmodule

>>> tb/tb_stereo_adpcm_block_decoder_core.sv
// Self-checking testbench for stereo_adpcm_block_decoder_core.
// Holds a bit-exact decode predictor, stimulus tasks and a sample checker.
// Depends on sadpcm_pkg and the decoder RTL only.
`timescale 1ns / 1ps

module tb_stereo_adpcm_block_decoder_core;
	import sadpcm_pkg::*;

	// No activity on either channel for this long means the block is hung.
	// The worst legal gap is one sample stall burst stacked on one send gap,
	// plus the input and sample registers.
	localparam int QuietLimit = 1000;

	// Predictor coefficients, per filter index
	localparam int GainRecent [4] = '{0, 60, 115, 98};
	localparam int GainOlder  [4] = '{0, 0, 52, 55};

	logic        clk          = 1'b0;
	logic        arst_n       = 1'b0;
	logic        byte_valid   = 1'b0;
	logic        byte_stall;
	sadpcm_in_t  byte_beat    = '0;
	logic        sample_valid;
	logic        sample_stall = 1'b0;
	sadpcm_out_t sample_beat;

	// Predictor state, mirrors the block's reset values
	logic [PosW-1:0] blk_pos    = '0;
	logic [7:0]      hdr_left   = '0;
	logic [7:0]      hdr_right  = '0;
	int              hist_l_new = 0;
	int              hist_l_old = 0;
	int              hist_r_new = 0;
	int              hist_r_old = 0;

	sadpcm_out_t due_samples [$];	// samples predicted, not yet seen on the output
	int          error_count = 0;
	bit          idle_en     = 1'b1;	// random send gaps and sample stalls
	int          stall_left  = 0;

	stereo_adpcm_block_decoder_core u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.byte_valid   (byte_valid),
		.byte_stall   (byte_stall),
		.byte_beat    (byte_beat),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.sample_beat  (sample_beat)
	);

	initial forever #4 clk = ~clk;

	// ------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------

	// One channel: 2nd-order prediction, round off 6 bits, clamp to 22 bits,
	// add the scaled nibble. The 23-bit sum becomes the new history; the
	// sample is that sum rounded by 6 bits and saturated to 16 bits.
	function automatic logic signed [15:0] nibble_to_sample(input logic [7:0] hdr,
			input logic [3:0] nib, inout int recent, inout int older);
		int     filt;
		int     sh;
		int     code;
		longint pred;
		longint sum;
		longint pcm;
		filt = int'(hdr[5:4]);
		sh   = int'(hdr[3:0]);
		pred = longint'(recent) * GainRecent[filt] - longint'(older) * GainOlder[filt];
		pred = (pred + 32) >>> 6;
		if (pred < -64'sh200000)
			pred = -64'sh200000;
		else if (pred > 64'sh1FFFFF)
			pred = 64'sh1FFFFF;
		code = int'(nib);
		if (code >= 8)
			code -= 16;
		sum    = pred + ((longint'(code) * 4096) >>> sh) * 64;
		older  = recent;
		recent = int'(sum);
		pcm    = (sum + 32) >>> 6;
		if (pcm < -32768)
			pcm = -32768;
		else if (pcm > 32767)
			pcm = 32767;
		return pcm[15:0];
	endfunction

	// Advance the block state by one byte; returns 1 when a sample results.
	function automatic bit decode_byte(input sadpcm_in_t b, output sadpcm_out_t s);
		logic [PosW-1:0] pos;
		pos = b.block_start ? PosLeftHdr : blk_pos;
		s = '0;
		decode_byte = 1'b0;
		// history clear takes effect before the byte itself
		if (b.clear_history) begin
			hist_l_new = 0;
			hist_l_old = 0;
			hist_r_new = 0;
			hist_r_old = 0;
		end
		if (pos == PosLeftHdr) begin
			hdr_left = b.data_byte;
		end else if (pos == PosRightHdr) begin
			hdr_right = b.data_byte;
		end else if (pos >= PosFirstData) begin
			// low nibble feeds left, high nibble feeds right
			s.left_sample  = nibble_to_sample(hdr_left, b.data_byte[3:0],
				hist_l_new, hist_l_old);
			s.right_sample = nibble_to_sample(hdr_right, b.data_byte[7:4],
				hist_r_new, hist_r_old);
			decode_byte = 1'b1;
		end
		// 5-bit position wraps after byte 31
		blk_pos = pos + 1'b1;
	endfunction

	// ------------------------------------------------------------------
	// Byte sender: entered and left at a falling edge
	// ------------------------------------------------------------------

	task automatic send_byte(input logic [7:0] d, input bit bs = 1'b0, input bit clr = 1'b0);
		sadpcm_out_t s;
		if (idle_en && $urandom_range(0, 7) == 0) begin
			byte_valid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(negedge clk);
		end
		byte_valid <= 1'b1;
		byte_beat  <= '{data_byte: d, block_start: bs, clear_history: clr};
		do @(posedge clk); while (byte_stall);
		// beat accepted at this edge; its sample follows through the input and sample registers
		if (decode_byte(byte_beat, s))
			due_samples.push_back(s);
		@(negedge clk);
	endtask

	// One block of random content; len < 32 gives a truncated block.
	task automatic send_block(input bit mark, input int len);
		for (int i = 0; i < len; i++)
			send_byte(8'($urandom_range(0, 255)), mark && i == 0,
				(i == 0) ? ($urandom_range(0, 7) == 0) : ($urandom_range(0, 199) == 0));
	endtask

	// ------------------------------------------------------------------
	// Sample stall: random bursts, none once idle_en drops
	// ------------------------------------------------------------------

	initial forever begin
		@(negedge clk);
		if (!idle_en)
			stall_left = 0;
		else if (stall_left > 0)
			stall_left--;
		else if ($urandom_range(0, 9) == 0)
			stall_left = $urandom_range(1, 19);
		sample_stall <= (stall_left > 0);
	end

	// ------------------------------------------------------------------
	// Sample checker: each accepted beat against the oldest prediction
	// ------------------------------------------------------------------

	always @(posedge clk) begin
		sadpcm_out_t want;
		if (sample_valid && !sample_stall) begin
			if (due_samples.size() == 0) begin
				error_count++;
				if (error_count <= 10)
					$display("%0t: unexpected sample beat L=%0d R=%0d", $realtime,
						sample_beat.left_sample, sample_beat.right_sample);
			end else begin
				want = due_samples.pop_front();
				if (want.left_sample !== sample_beat.left_sample ||
						want.right_sample !== sample_beat.right_sample) begin
					error_count++;
					if (error_count <= 10)
						$display("%0t: sample mismatch exp L=%0d R=%0d got L=%0d R=%0d",
							$realtime, want.left_sample, want.right_sample,
							sample_beat.left_sample, sample_beat.right_sample);
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Watchdog: too long without any beat on either channel
	// ------------------------------------------------------------------

	initial begin
		int quiet;
		quiet = 0;
		while (quiet < QuietLimit) begin
			@(posedge clk);
			if ((byte_valid && !byte_stall) || (sample_valid && !sample_stall))
				quiet = 0;
			else
				quiet++;
		end
		$display("Simulation FAILED");
		$finish;
	end

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Header bits 7:6 set and ignored, filter 1 at shift 0 driven into both
	// saturation rails; right channel at filter 3, shift 15 (code -> 0/-1).
	task automatic test_headers_and_saturation();
		send_byte(8'hD0, 1'b1, 1'b1);
		send_byte(8'h3F);
		send_byte(8'hFF);
		send_byte(8'h00);
		repeat (4) send_byte(8'h77);	// max positive code, left clips high
		repeat (5) send_byte(8'h88);	// most negative code, left heads to low rail
	endtask

	// Filter 2 and filter 0, mixed nibble signs, a history clear on a data
	// byte, then block_start in the middle of a block to realign.
	task automatic test_realign_and_clear();
		send_byte(8'h20, 1'b1);
		send_byte(8'h0C);
		send_byte(8'h55);
		send_byte(8'hAA);
		send_byte(8'h7F);
		send_byte(8'hF7);
		send_byte(8'h80, 1'b0, 1'b1);
		send_byte(8'h08);
		send_byte(8'hB3, 1'b1);	// realign: byte taken as left header
		send_byte(8'hE4);
		send_byte(8'h01);
		send_byte(8'hFE);
		send_byte(8'h19);
		send_byte(8'hE2);
	endtask

	// Mostly whole blocks, many without block_start so the position wrap
	// supplies alignment; some truncated blocks, each followed by a marked one.
	task automatic test_random_blocks();
		bit short_prev;
		int len;
		short_prev = 1'b1;
		repeat (38) begin
			len = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 31) : 32;
			send_block(short_prev || $urandom_range(0, 1), len);
			short_prev = (len != 32);
		end
	endtask

	// Unstructured bytes with frequent realignment and history clears.
	task automatic test_noise();
		repeat (150)
			send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0,
				$urandom_range(0, 15) == 0);
	endtask

	// Full rate on both sides to close the run.
	task automatic test_unthrottled_tail();
		idle_en = 1'b0;
		send_block(1'b1, 32);
		send_block(1'b0, 32);
	endtask

	initial begin
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_headers_and_saturation();
		test_realign_and_clear();
		test_random_blocks();
		test_noise();
		test_unthrottled_tail();
		byte_valid <= 1'b0;

		// drain; a hang here is caught by the watchdog
		while (due_samples.size() != 0) @(posedge clk);
		repeat (6) @(posedge clk);

		if (error_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
